### design/frc_pkg.sv
package frc_pkg;

  // Ring geometry
  localparam int NUM_FRAMES  = 16;
  localparam int FRAME_BYTES = 256;

  // Field widths fixed by the port list
  localparam int CMD_W  = 4;
  localparam int TS_W   = 32;
  localparam int BYTE_W = 8;
  localparam int CNT_W  = 9;

  // Derived widths
  localparam int SLOT_W     = $clog2(NUM_FRAMES);
  localparam int OFF_W      = $clog2(FRAME_BYTES);
  localparam int LEN_W      = $clog2(FRAME_BYTES + 1);
  localparam int CMP_W      = (LEN_W > CNT_W) ? LEN_W : CNT_W;
  localparam int BADDR_W    = SLOT_W + OFF_W;
  localparam int BYTE_DEPTH = 2 ** BADDR_W;

  typedef logic [SLOT_W-1:0] slot_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_RESET     = 4'd0,
    CMD_START_RX  = 4'd1,
    CMD_START_TX  = 4'd2,
    CMD_STORE     = 4'd3,
    CMD_REMOVE    = 4'd4,
    CMD_ABORT     = 4'd5,
    CMD_END_VALID = 4'd6,
    CMD_END_GAP   = 4'd7,
    CMD_READ      = 4'd8,
    CMD_RELEASE   = 4'd9
  } cmd_t;

  // Per-slot metadata; a slot's valid bit doubles as its started flag
  typedef struct packed {
    logic [TS_W-1:0]  start_ts;
    logic [TS_W-1:0]  end_ts;
    logic [LEN_W-1:0] len;
    logic             tx;
    logic             gap;
    logic             ok;
    logic             ready;
  } meta_t;

  localparam int META_W = $bits(meta_t);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_POST
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic latch;
    logic exec;
    logic fetch;
  } ctl_t;

  function automatic slot_t next_slot(slot_t s);
    next_slot = (s == slot_t'(NUM_FRAMES - 1)) ? '0 : slot_t'(s + 1'b1);
  endfunction

endpackage

### design/frc_ram.sv
module frc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, held when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

### design/frc_ctrl.sv
module frc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  output frc_pkg::ctl_t ctl,
  output logic          out_strobe
);

  import frc_pkg::*;

  state_t state_r, state_nxt;
  logic   strobe_r, strobe_nxt;

  // State and strobe registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  // Next state and commands: execute, then fetch the updated slots
  always_comb begin
    busy       = (state_r == ST_EXEC);
    ctl.latch  = start && !busy;
    ctl.exec   = (state_r == ST_EXEC);
    ctl.fetch  = (state_r == ST_POST);
    strobe_nxt = (state_r == ST_POST);
    state_nxt  = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        state_nxt = ST_POST;
      end
      ST_POST: begin
        state_nxt = start ? ST_EXEC : ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_strobe = strobe_r;

endmodule

### design/frc_datapath.sv
module frc_datapath (
  input  logic                       clk,
  input  logic                       rst_n,
  input  frc_pkg::ctl_t              ctl,
  input  logic [frc_pkg::CMD_W-1:0]  in_command,
  input  logic [frc_pkg::TS_W-1:0]   in_timestamp,
  input  logic [frc_pkg::BYTE_W-1:0] in_data_byte,
  input  logic [frc_pkg::CNT_W-1:0]  in_count,
  output logic [frc_pkg::CNT_W-1:0]  out_write_len,
  output logic [frc_pkg::TS_W-1:0]   out_write_start,
  output logic                       out_head_available,
  output logic [frc_pkg::TS_W-1:0]   out_head_start,
  output logic [frc_pkg::TS_W-1:0]   out_head_end,
  output logic [frc_pkg::CNT_W-1:0]  out_head_len,
  output logic                       out_head_is_tx,
  output logic                       out_head_gap_timeout,
  output logic                       out_head_valid,
  output logic [frc_pkg::BYTE_W-1:0] out_head_byte
);

  import frc_pkg::*;

  // Latched command beat
  logic [CMD_W-1:0]  cmd_r;
  logic [TS_W-1:0]   ts_r;
  logic [BYTE_W-1:0] byte_r;
  logic [CNT_W-1:0]  cnt_r;

  // Ring state
  slot_t                 w_r, w_nxt;
  slot_t                 rd_r, rd_nxt;
  logic [NUM_FRAMES-1:0] vld_r, vld_nxt;

  // Snapshot taken with the slot fetch
  logic             vw_r, vh_r, same_r, rep_read_r;
  logic [CNT_W-1:0] rep_cnt_r;

  // Memory ports
  meta_t              qw, qh, mw, mh, m_wd;
  logic               m_we, b_we;
  logic [BADDR_W-1:0] b_wa, b_ra;
  logic [BYTE_W-1:0]  b_q;

  logic [CMP_W-1:0] len_ext, cnt_ext, hlen_ext, rcnt_ext;
  logic             avail;

  // Latch the command beat on accept
  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      cmd_r  <= in_command;
      ts_r   <= in_timestamp;
      byte_r <= in_data_byte;
      cnt_r  <= in_count;
    end
  end

  // Indices and slot valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r   <= '0;
      rd_r  <= '0;
      vld_r <= '0;
    end else begin
      w_r   <= w_nxt;
      rd_r  <= rd_nxt;
      vld_r <= vld_nxt;
    end
  end

  // Capture valid bits and read context alongside the memory fetch
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vw_r       <= 1'b0;
      vh_r       <= 1'b0;
      same_r     <= 1'b1;
      rep_read_r <= 1'b0;
    end else if (ctl.fetch) begin
      vw_r       <= vld_r[w_r];
      vh_r       <= vld_r[rd_r];
      same_r     <= (w_r == rd_r);
      rep_read_r <= (cmd_r == CMD_READ);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.fetch) begin
      rep_cnt_r <= cnt_r;
    end
  end

  // Unwritten or cleared slots read as zero
  assign mw = vw_r ? qw : '0;
  assign mh = vh_r ? qh : '0;

  assign len_ext = CMP_W'(mw.len);
  assign cnt_ext = CMP_W'(cnt_r);
  assign b_wa    = {w_r, OFF_W'(mw.len)};
  assign b_ra    = {rd_r, OFF_W'(cnt_r)};

  // Execute the command on the fetched slots
  always_comb begin
    m_we    = 1'b0;
    m_wd    = mw;
    b_we    = 1'b0;
    w_nxt   = w_r;
    rd_nxt  = rd_r;
    vld_nxt = vld_r;
    if (ctl.exec) begin
      case (cmd_t'(cmd_r))
        CMD_RESET: begin
          w_nxt   = '0;
          rd_nxt  = '0;
          vld_nxt = '0;
        end
        CMD_START_RX, CMD_START_TX: begin
          m_wd          = '0;
          m_wd.start_ts = ts_r;
          m_wd.tx       = (cmd_r == CMD_START_TX);
          m_we          = 1'b1;
          vld_nxt[w_r]  = 1'b1;
        end
        CMD_STORE: begin
          if (vw_r && (mw.len < LEN_W'(FRAME_BYTES))) begin
            m_wd.len = LEN_W'(mw.len + 1'b1);
            m_we     = 1'b1;
            b_we     = 1'b1;
          end
        end
        CMD_REMOVE: begin
          if ((cnt_r != '0) && vw_r && (len_ext >= cnt_ext)) begin
            m_wd.len = LEN_W'(len_ext - cnt_ext);
            m_we     = 1'b1;
          end
        end
        CMD_ABORT: begin
          vld_nxt[w_r] = 1'b0;
        end
        CMD_END_VALID: begin
          if (vw_r) begin
            m_wd.end_ts = ts_r;
            m_wd.ok     = 1'b1;
            m_wd.ready  = 1'b1;
            m_we        = 1'b1;
            w_nxt       = next_slot(w_r);
          end
        end
        CMD_END_GAP: begin
          if (vw_r && !mw.ok && !mw.ready) begin
            m_wd.end_ts = ts_r;
            m_wd.gap    = 1'b1;
            m_wd.ready  = 1'b1;
            m_we        = 1'b1;
            w_nxt       = next_slot(w_r);
          end
        end
        CMD_RELEASE: begin
          if ((w_r != rd_r) && vh_r && mh.ready) begin
            vld_nxt[rd_r] = 1'b0;
            rd_nxt        = next_slot(rd_r);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Metadata, one copy per read side
  frc_ram #(.WIDTH(META_W), .DEPTH(NUM_FRAMES)) u_meta_w (
    .clk     (clk),
    .we      (m_we),
    .waddr   (w_r),
    .wdata   (m_wd),
    .re      (ctl.fetch),
    .raddr   (w_r),
    .rdata_r (qw)
  );

  frc_ram #(.WIDTH(META_W), .DEPTH(NUM_FRAMES)) u_meta_h (
    .clk     (clk),
    .we      (m_we),
    .waddr   (w_r),
    .wdata   (m_wd),
    .re      (ctl.fetch),
    .raddr   (rd_r),
    .rdata_r (qh)
  );

  // Frame bytes
  frc_ram #(.WIDTH(BYTE_W), .DEPTH(BYTE_DEPTH)) u_bytes (
    .clk     (clk),
    .we      (b_we),
    .waddr   (b_wa),
    .wdata   (byte_r),
    .re      (ctl.fetch),
    .raddr   (b_ra),
    .rdata_r (b_q)
  );

  // Result from the fetched slots
  assign hlen_ext = CMP_W'(mh.len);
  assign rcnt_ext = CMP_W'(rep_cnt_r);
  assign avail    = !same_r && vh_r && qh.ready;

  always_comb begin
    out_write_len        = vw_r ? CNT_W'(qw.len) : '0;
    out_write_start      = vw_r ? qw.start_ts : '0;
    out_head_available   = avail;
    out_head_start       = avail ? mh.start_ts : '0;
    out_head_end         = avail ? mh.end_ts : '0;
    out_head_len         = avail ? CNT_W'(mh.len) : '0;
    out_head_is_tx       = avail && mh.tx;
    out_head_gap_timeout = avail && mh.gap;
    out_head_valid       = avail && mh.ok;
    out_head_byte        = (avail && rep_read_r && (rcnt_ext < hlen_ext) &&
                            (rcnt_ext < CMP_W'(FRAME_BYTES))) ? b_q : '0;
  end

endmodule

### design/frame_capture_ring_unit.sv
// Frame capture ring. A command beat is taken at a clock edge where start is
// high and busy is low; busy is then high for one cycle while the command
// updates the slot metadata, and the next cycle fetches the updated write and
// head slots (and the head byte for a read). The result is on the out_ ports
// in the cycle after the fetch, marked by out_strobe, and cannot be held
// off: capture it in that cycle. A new command can be taken in the fetch
// cycle, so with start held high the block takes a new command while the
// result of the last one is still to come. Command spacing is set by the
// metadata RAM: a slot is written in the execute cycle, read back in fetch.
module frame_capture_ring_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [frc_pkg::CMD_W-1:0]  in_command,
  input  logic [frc_pkg::TS_W-1:0]   in_timestamp,
  input  logic [frc_pkg::BYTE_W-1:0] in_data_byte,
  input  logic [frc_pkg::CNT_W-1:0]  in_count,
  output logic                       out_strobe,
  output logic [frc_pkg::CNT_W-1:0]  out_write_len,
  output logic [frc_pkg::TS_W-1:0]   out_write_start,
  output logic                       out_head_available,
  output logic [frc_pkg::TS_W-1:0]   out_head_start,
  output logic [frc_pkg::TS_W-1:0]   out_head_end,
  output logic [frc_pkg::CNT_W-1:0]  out_head_len,
  output logic                       out_head_is_tx,
  output logic                       out_head_gap_timeout,
  output logic                       out_head_valid,
  output logic [frc_pkg::BYTE_W-1:0] out_head_byte
);

  import frc_pkg::*;

  ctl_t ctl;

  frc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .ctl        (ctl),
    .out_strobe (out_strobe)
  );

  frc_datapath u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .ctl                  (ctl),
    .in_command           (in_command),
    .in_timestamp         (in_timestamp),
    .in_data_byte         (in_data_byte),
    .in_count             (in_count),
    .out_write_len        (out_write_len),
    .out_write_start      (out_write_start),
    .out_head_available   (out_head_available),
    .out_head_start       (out_head_start),
    .out_head_end         (out_head_end),
    .out_head_len         (out_head_len),
    .out_head_is_tx       (out_head_is_tx),
    .out_head_gap_timeout (out_head_gap_timeout),
    .out_head_valid       (out_head_valid),
    .out_head_byte        (out_head_byte)
  );

endmodule

### design/frc_checker.sv
module frc_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       start,
  input logic                       busy,
  input logic                       out_strobe,
  input logic [frc_pkg::CNT_W-1:0]  out_write_len,
  input logic                       out_head_available,
  input logic [frc_pkg::CNT_W-1:0]  out_head_len,
  input logic [frc_pkg::BYTE_W-1:0] out_head_byte
);

  import frc_pkg::*;

  // Every accepted beat is followed by a result strobe
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##3 out_strobe)
    else $error("result strobe missing after accepted command");

  // Busy covers the execute cycle only
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy ##1 !busy))
    else $error("busy not one cycle after accept");

  // Results never come back to back
  a_strobe_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobes in consecutive cycles");

  // No head frame: head fields read as zero
  a_head_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_head_available) |-> (out_head_len == '0 && out_head_byte == '0))
    else $error("head fields set with no head frame");

  // Write length never exceeds the frame size
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (CMP_W'(out_write_len) <= CMP_W'(FRAME_BYTES)))
    else $error("write length beyond frame size");

endmodule

bind frame_capture_ring_unit frc_checker u_frc_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .start              (start),
  .busy               (busy),
  .out_strobe         (out_strobe),
  .out_write_len      (out_write_len),
  .out_head_available (out_head_available),
  .out_head_len       (out_head_len),
  .out_head_byte      (out_head_byte)
);
